// ===== hw/rtl/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants of the deadline timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

	localparam int ENTRIES_DEF   = 16;
	localparam int HANDLES_DEF   = 64;
	localparam int TIME_BITS_DEF = 48;
	localparam int ORDER_BITS    = 32;
	localparam int KIND_W        = 3;

	typedef enum logic [1:0] {
		ACT_ARM    = 2'd0,
		ACT_CANCEL = 2'd1,
		ACT_TICK   = 2'd2,
		ACT_DROP   = 2'd3
	} act_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_DUE       = 3'd0,
		KIND_CANCELLED = 3'd1,
		KIND_IMMEDIATE = 3'd2,
		KIND_FULL      = 3'd3,
		KIND_LIVE      = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ACT,
		ST_PUSH,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the accepted beat
		logic drop;      // empty the store
		logic scan_clr;  // restart the slot scan
		logic scan_go;   // advance the slot scan
		logic commit;    // store an arm or kill a cancelled entry
		logic remove;    // free the best due entry
		logic pend_load; // keep the best due handle as pending result
		logic emit;      // load the output register
		logic emit_last; // the emitted beat ends this item
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		act_t action;
		logic scan_done;
		logic has_result;
		logic best_found;
		logic best_live;
		logic pend_valid;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dtq_if.sv =====
// ----------------------------------------------------------------------------
// dtq_if
// Request and result channels of the deadline timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtq_req_if #(
	parameter int HW = 6,
	parameter int TW = 48
);
	logic          valid;
	logic          ready;
	logic [1:0]    action;
	logic [HW-1:0] handle;
	logic [TW-1:0] deadline;
	logic [TW-1:0] now;

	modport source (output valid, action, handle, deadline, now, input ready);
	modport sink (input valid, action, handle, deadline, now, output ready);
endinterface

interface dtq_res_if #(
	parameter int HW = 6
);
	logic          valid;
	logic          ready;
	logic [HW-1:0] out_handle;
	logic [2:0]    kind;
	logic          last;

	modport source (output valid, out_handle, kind, last, input ready);
	modport sink (input valid, out_handle, kind, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtq_ctrl
// Controller: sequences the slot scans, commits and result beats of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  dtq_pkg::status_t status,
	output dtq_pkg::cmd_t    cmd
);
	import dtq_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load     = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d      = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_go = 1'b1;
				if (status.scan_done) begin
					state_d = ST_ACT;
				end
			end
			ST_ACT: begin
				case (status.action)
					ACT_TICK: begin
						if (status.best_found && status.best_live && status.pend_valid) begin
							state_d = ST_PUSH;
						end else if (status.best_found) begin
							cmd.remove    = 1'b1;
							cmd.pend_load = status.best_live;
							cmd.scan_clr  = 1'b1;
							state_d       = ST_SCAN;
						end else if (status.pend_valid) begin
							state_d = ST_EMIT;
						end else begin
							state_d = ST_IDLE;
						end
					end
					ACT_DROP: begin
						cmd.drop = 1'b1;
						state_d  = ST_IDLE;
					end
					default: begin
						cmd.commit = 1'b1;
						state_d    = status.has_result ? ST_EMIT : ST_IDLE;
					end
				endcase
			end
			ST_PUSH: begin
				if (status.out_free) begin
					cmd.emit      = 1'b1;
					cmd.remove    = 1'b1;
					cmd.pend_load = 1'b1;
					cmd.scan_clr  = 1'b1;
					state_d       = ST_SCAN;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/dtq_datapath.sv =====
// ----------------------------------------------------------------------------
// dtq_datapath
// Datapath: slot memory, valid and live bits, scan compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_datapath #(
	parameter int ENTRIES   = 16,
	parameter int HANDLES   = 64,
	parameter int TIME_BITS = 48
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire [1:0]                    in_action,
	input  wire [$clog2(HANDLES)-1:0]    in_handle,
	input  wire [TIME_BITS-1:0]          in_deadline,
	input  wire [TIME_BITS-1:0]          in_now,
	input  dtq_pkg::cmd_t                cmd,
	output dtq_pkg::status_t             status,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [$clog2(HANDLES)-1:0]   out_handle,
	output logic [2:0]                   out_kind,
	output logic                         out_last
);
	import dtq_pkg::*;

	localparam int HW = $clog2(HANDLES);
	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int MW = TIME_BITS + ORDER_BITS + HW;

	// Slot memory: {deadline, arm order, handle}.
	logic [MW-1:0] mem [ENTRIES];

	logic [ENTRIES-1:0]    valid_q, live_q;
	logic [ORDER_BITS-1:0] ctr_q;

	act_t                 action_q;
	logic [HW-1:0]        handle_q;
	logic [TIME_BITS-1:0] deadline_q, now_q;

	logic [CW-1:0] scan_idx_q;
	logic [AW-1:0] idx_s1;
	logic          chk_s1;
	logic [MW-1:0] rd_s1;

	logic          found_q, free_found_q, best_found_q;
	logic [AW-1:0] found_idx_q, free_idx_q, best_idx_q;
	logic [TIME_BITS-1:0]  best_dl_q;
	logic [ORDER_BITS-1:0] best_ord_q;
	logic [HW-1:0]         best_handle_q;

	logic          pend_valid_q;
	logic [HW-1:0] pend_handle_q;

	logic                  out_valid_q, out_last_q;
	logic [HW-1:0]         out_handle_q;
	kind_t                 out_kind_q;

	logic [TIME_BITS-1:0]  rd_dl;
	logic [ORDER_BITS-1:0] rd_ord;
	logic [HW-1:0]         rd_handle;
	logic                  rd_valid, rd_live, better;
	logic                  has_result;
	kind_t                 res_kind;

	assign rd_dl     = rd_s1[MW-1 -: TIME_BITS];
	assign rd_ord    = rd_s1[HW +: ORDER_BITS];
	assign rd_handle = rd_s1[HW-1:0];
	assign rd_valid  = valid_q[idx_s1];
	assign rd_live   = live_q[idx_s1];
	assign better    = !best_found_q || (rd_dl < best_dl_q) ||
	                   ((rd_dl == best_dl_q) && (rd_ord < best_ord_q));

	// Outcome of an arm or cancel once the scan is over.
	always_comb begin
		has_result = 1'b0;
		res_kind   = KIND_DUE;
		case (action_q)
			ACT_ARM: begin
				has_result = 1'b1;
				if (found_q) begin
					res_kind = KIND_LIVE;
				end else if (deadline_q <= now_q) begin
					res_kind = KIND_IMMEDIATE;
				end else if (!free_found_q) begin
					res_kind = KIND_FULL;
				end else begin
					has_result = 1'b0;
				end
			end
			ACT_CANCEL: begin
				has_result = found_q;
				res_kind   = KIND_CANCELLED;
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q   <= act_t'(in_action);
			handle_q   <= in_handle;
			deadline_q <= in_deadline;
			now_q      <= in_now;
		end
		if (cmd.scan_go && (scan_idx_q != CW'(ENTRIES))) begin
			rd_s1  <= mem[scan_idx_q[AW-1:0]];
			idx_s1 <= scan_idx_q[AW-1:0];
		end
		if (cmd.commit && (action_q == ACT_ARM) && !has_result) begin
			mem[free_idx_q] <= {deadline_q, ctr_q, handle_q};
		end
		if (chk_s1) begin
			if (rd_valid && rd_live && (rd_handle == handle_q) && !found_q) begin
				found_idx_q <= idx_s1;
			end
			if (!rd_valid && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
			if (rd_valid && (rd_dl <= now_q) && better) begin
				best_idx_q    <= idx_s1;
				best_dl_q     <= rd_dl;
				best_ord_q    <= rd_ord;
				best_handle_q <= rd_handle;
			end
		end
		if (cmd.pend_load) begin
			pend_handle_q <= best_handle_q;
		end
		if (cmd.emit) begin
			out_last_q <= cmd.emit_last;
			if (action_q == ACT_TICK) begin
				out_handle_q <= pend_handle_q;
				out_kind_q   <= KIND_DUE;
			end else begin
				out_handle_q <= handle_q;
				out_kind_q   <= res_kind;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			live_q       <= '0;
			ctr_q        <= '0;
			scan_idx_q   <= '0;
			chk_s1       <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				pend_valid_q <= 1'b0;
			end
			if (cmd.scan_clr) begin
				scan_idx_q   <= '0;
				chk_s1       <= 1'b0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				best_found_q <= 1'b0;
			end else begin
				if (cmd.scan_go && (scan_idx_q != CW'(ENTRIES))) begin
					scan_idx_q <= scan_idx_q + CW'(1);
					chk_s1     <= 1'b1;
				end else begin
					chk_s1 <= 1'b0;
				end
				if (chk_s1) begin
					if (rd_valid && rd_live && (rd_handle == handle_q)) begin
						found_q <= 1'b1;
					end
					if (!rd_valid) begin
						free_found_q <= 1'b1;
					end
					if (rd_valid && (rd_dl <= now_q)) begin
						best_found_q <= 1'b1;
					end
				end
			end
			if (cmd.commit) begin
				if ((action_q == ACT_ARM) && !has_result) begin
					valid_q[free_idx_q] <= 1'b1;
					live_q[free_idx_q]  <= 1'b1;
					ctr_q               <= ctr_q + ORDER_BITS'(1);
				end else if ((action_q == ACT_CANCEL) && found_q) begin
					live_q[found_idx_q] <= 1'b0;
				end
			end
			if (cmd.remove) begin
				valid_q[best_idx_q] <= 1'b0;
				live_q[best_idx_q]  <= 1'b0;
			end
			if (cmd.pend_load) begin
				pend_valid_q <= 1'b1;
			end
			if (cmd.drop) begin
				valid_q <= '0;
				live_q  <= '0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.action     = action_q;
	assign status.scan_done  = (scan_idx_q == CW'(ENTRIES)) && !chk_s1;
	assign status.has_result = has_result;
	assign status.best_found = best_found_q;
	assign status.best_live  = live_q[best_idx_q];
	assign status.pend_valid = pend_valid_q;
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_handle = out_handle_q;
	assign out_kind   = out_kind_q;
	assign out_last   = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/deadline_timer_queue.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Top level: a store of armed waits that fires them by deadline and arm order.
// ----------------------------------------------------------------------------
// One request beat is taken at a time; the next is accepted once every result
// beat of the previous one has been loaded into the output register. Every
// request, drop-all included, first sweeps the slot memory, one slot per cycle
// through its single read port. A request that returns a result beat may also
// wait on the result channel. A tick repeats that sweep once for each entry it
// removes and once more to find that none is left due. Result beats are staged
// in an output register, so the downstream side can stall without losing a
// beat; the beat that ends an item carries last. No clearing pass runs after
// reset.
`default_nettype none

module deadline_timer_queue #(
	parameter int ENTRIES   = dtq_pkg::ENTRIES_DEF,
	parameter int HANDLES   = dtq_pkg::HANDLES_DEF,
	parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEF
) (
	input  wire     clk,
	input  wire     arst_n,
	dtq_req_if.sink req,
	dtq_res_if.source res
);
	import dtq_pkg::*;

	cmd_t    cmd;
	status_t status;

	// The controller owns the sequencing; it sees the datapath only through
	// the command and status structs.
	dtq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the slots, the scan compare and the result register.
	dtq_datapath #(
		.ENTRIES   (ENTRIES),
		.HANDLES   (HANDLES),
		.TIME_BITS (TIME_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_action   (req.action),
		.in_handle   (req.handle),
		.in_deadline (req.deadline),
		.in_now      (req.now),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (res.valid),
		.out_ready   (res.ready),
		.out_handle  (res.out_handle),
		.out_kind    (res.kind),
		.out_last    (res.last)
	);

endmodule

`default_nettype wire

// ===== bench/deadline_timer_queue_scoreboard.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_queue_scoreboard
// Predicts the result beats of the deadline timer queue and checks them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtq_check_pkg;
	import dtq_pkg::*;

	localparam int NSLOTS = 16;

	typedef struct packed {
		logic [5:0] handle;
		kind_t      kind;
		logic       last;
	} fire_t;

	class timer_scoreboard;
		logic [47:0] deadline_q[NSLOTS];
		logic [31:0] order_q[NSLOTS];
		logic [5:0]  handle_q[NSLOTS];
		bit          used[NSLOTS];
		bit          armed[NSLOTS];
		logic [31:0] arm_seq;
		fire_t       batch[$];
		fire_t       pending[$];
		int          errors;

		function new();
			for (int i = 0; i < NSLOTS; i++) begin
				used[i] = 0;
				armed[i] = 0;
			end
			arm_seq = 0;
			errors = 0;
		endfunction

		function int armed_slot(logic [5:0] h);
			for (int i = 0; i < NSLOTS; i++)
				if (used[i] && armed[i] && handle_q[i] == h)
					return i;
			return -1;
		endfunction

		function int free_count();
			int n;
			n = 0;
			for (int i = 0; i < NSLOTS; i++)
				if (!used[i])
					n++;
			return n;
		endfunction

		// Appends one result beat to the batch of the current request.
		function void stage(logic [5:0] h, kind_t k);
			fire_t f;
			f.handle = h;
			f.kind = k;
			f.last = 1'b0;
			batch = {batch, f};
		endfunction

		// Works out the result beats of one accepted request beat.
		function void note_request(act_t act, logic [5:0] h, logic [47:0] dl,
				logic [47:0] now);
			int    slot;
			int    best;
			slot = -1;
			batch.delete();
			case (act)
				ACT_ARM: begin
					if (armed_slot(h) >= 0)
						stage(h, KIND_LIVE);
					else if (dl <= now)
						stage(h, KIND_IMMEDIATE);
					else begin
						for (int i = 0; i < NSLOTS; i++)
							if (!used[i] && slot < 0)
								slot = i;
						if (slot < 0)
							stage(h, KIND_FULL);
						else begin
							deadline_q[slot] = dl;
							order_q[slot] = arm_seq;
							handle_q[slot] = h;
							used[slot] = 1;
							armed[slot] = 1;
							arm_seq++;
						end
					end
				end
				ACT_CANCEL: begin
					slot = armed_slot(h);
					if (slot >= 0) begin
						armed[slot] = 0;
						stage(h, KIND_CANCELLED);
					end
				end
				ACT_TICK: begin
					do begin
						best = -1;
						for (int i = 0; i < NSLOTS; i++)
							if (used[i] && deadline_q[i] <= now)
								if (best < 0 || deadline_q[i] < deadline_q[best] ||
										(deadline_q[i] == deadline_q[best] &&
										order_q[i] < order_q[best]))
									best = i;
						if (best >= 0) begin
							if (armed[best])
								stage(handle_q[best], KIND_DUE);
							used[best] = 0;
							armed[best] = 0;
						end
					end while (best >= 0);
				end
				default: begin
					for (int i = 0; i < NSLOTS; i++) begin
						used[i] = 0;
						armed[i] = 0;
					end
				end
			endcase
			if (batch.size() > 0)
				batch[batch.size() - 1].last = 1'b1;
			pending = {pending, batch};
		endfunction

		function void report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endfunction

		function void check_result(logic [5:0] h, logic [2:0] k, logic l);
			fire_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected beat handle %0d kind %0d", h, k));
				return;
			end
			want = pending.pop_front();
			if (h !== want.handle)
				report($sformatf("handle %0d, wanted %0d", h, want.handle));
			if (k !== want.kind)
				report($sformatf("kind %0d, wanted %0d", k, want.kind));
			if (l !== want.last)
				report($sformatf("last %0d, wanted %0d", l, want.last));
		endfunction
	endclass
endpackage

// ===== bench/deadline_timer_queue_test.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_queue_test
// Drives arm, cancel, tick and drop-all beats into the timer queue and checks
// every result beat against a behavioral prediction of the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deadline_timer_queue_test;
	import dtq_pkg::*;
	import dtq_check_pkg::*;

	localparam longint CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	longint cycles;
	logic [47:0] clock_now;   // advancing notion of time for the random part
	logic [5:0]  pool_base;   // small handle pool so cancels and re-arms hit

	timer_scoreboard board;

	dtq_req_if #(.HW(6), .TW(48)) req ();
	dtq_res_if #(.HW(6)) res ();

	deadline_timer_queue uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A cycle counter guards against a hung block.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("deadline_timer_queue_test NOT OK");
			$finish;
		end
	end

	// Predict on every accepted request beat and check every accepted result
	// beat, both sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready)
			board.note_request(act_t'(req.action), req.handle, req.deadline, req.now);
		if (arst_n && res.valid && res.ready)
			board.check_result(res.out_handle, res.kind, res.last);
	end

	// The receiver stalls at random; its ready changes at the falling edge.
	always @(negedge clk) begin
		res.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Offers one request beat and holds it until it is accepted. Valid is
	// low on entry, so the sender idles simply by waiting.
	task automatic send(act_t act, logic [5:0] h, logic [47:0] dl, logic [47:0] now);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		req.valid <= 1'b1;
		req.action <= act;
		req.handle <= h;
		req.deadline <= dl;
		req.now <= now;
		do
			@(posedge clk);
		while (!req.ready);
		@(negedge clk);
		req.valid <= 1'b0;
	endtask

	task automatic drain();
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	// One random beat: mostly arms and ticks around an advancing time, with
	// cancels of recent handles, rare drop-all and occasional wild values.
	task automatic random_beat();
		int          pick;
		logic [5:0]  h;
		logic [47:0] dl;
		pick = $urandom_range(99);
		h = pool_base + 6'($urandom_range(11));
		if ($urandom_range(9) == 0)
			h = 6'($urandom);
		if (pick < 45) begin
			dl = clock_now + 48'($urandom_range(40)) - 48'd4;
			if ($urandom_range(19) == 0)
				dl = 48'({$urandom, $urandom});
			send(ACT_ARM, h, dl, clock_now);
		end else if (pick < 65) begin
			send(ACT_CANCEL, h, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
		end else if (pick < 97) begin
			clock_now = clock_now + 48'($urandom_range(12));
			send(ACT_TICK, h, 48'({$urandom, $urandom}), clock_now);
		end else begin
			send(ACT_DROP, h, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
		end
		if ($urandom_range(49) == 0)
			pool_base = 6'($urandom);
	endtask

	initial begin
		board = new();
		clk = 1'b0;
		cycles = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.action = ACT_ARM;
		req.handle = '0;
		req.deadline = '0;
		req.now = '0;
		res.ready = 1'b0;
		send_idle_pct = 33;
		recv_idle_pct = 49;
		clock_now = 48'd1000;
		pool_base = 6'd0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: every action, every kind and the time extremes.
		send(ACT_ARM, 6'd0, 48'd0, 48'd0);                    // immediate, both zero
		send(ACT_ARM, 6'd63, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFE);
		send(ACT_ARM, 6'd63, 48'd5, 48'd0);                   // already live
		send(ACT_CANCEL, 6'd63, 48'd0, 48'd0);                // cancelled
		send(ACT_CANCEL, 6'd63, 48'd0, 48'd0);                // no longer live
		send(ACT_ARM, 6'd63, 48'd1, 48'd0);                   // same handle again
		send(ACT_ARM, 6'd21, 48'd1, 48'd0);                   // tie, later order
		send(ACT_ARM, 6'd42, 48'd0, 48'hFFFF_FFFF_FFFF);      // immediate
		send(ACT_TICK, 6'd0, 48'd0, 48'd0);                   // nothing due
		send(ACT_TICK, 6'd0, 48'd0, 48'hFFFF_FFFF_FFFF);      // all due, dead one silent
		for (int i = 0; i < 17; i++)                          // fill, then full
			send(ACT_ARM, 6'(i), 48'd100 - 48'(i % 3), 48'd10);
		send(ACT_DROP, 6'd0, 48'd0, 48'd0);
		send(ACT_TICK, 6'd0, 48'd0, 48'hFFFF_FFFF_FFFF);      // store is empty
		drain();

		// Random part in three idling regimes, with one full pause mid-way.
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct = 49;
				recv_idle_pct = 33;
			end else if (phase == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int n = 0; n < 144; n++) begin
				random_beat();
				if (phase == 0 && n == 70)
					drain();
			end
		end

		drain();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("deadline_timer_queue_test OK");
		else
			$display("deadline_timer_queue_test NOT OK");
		$finish;
	end
endmodule

// ===== sim.f =====
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_if.sv
hw/rtl/dtq_ctrl.sv
hw/rtl/dtq_datapath.sv
hw/rtl/deadline_timer_queue.sv
bench/deadline_timer_queue_scoreboard.sv
bench/deadline_timer_queue_test.sv
